// File: rtl/core/u16u8_pkg.sv
// Package for the UTF-16 to UTF-8 converter: surrogate constants, the
// encoded-item struct passed between stages and the single-unit encoder.
// No dependencies.
package u16u8_pkg;

	localparam logic [15:0] HI_SURR_FIRST = 16'hD800;
	localparam logic [15:0] HI_SURR_LAST  = 16'hDBFF;
	localparam logic [15:0] LO_SURR_FIRST = 16'hDC00;
	localparam logic [15:0] LO_SURR_LAST  = 16'hDFFF;
	localparam logic [20:0] SUPP_BASE     = 21'h10000;
	localparam logic [15:0] ONE_BYTE_MAX  = 16'h007F;
	localparam logic [15:0] TWO_BYTE_MAX  = 16'h07FF;

	localparam logic [7:0] LEAD4 = 8'hF0;
	localparam logic [7:0] LEAD3 = 8'hE0;
	localparam logic [7:0] LEAD2 = 8'hC0;
	localparam logic [7:0] CONT  = 8'h80;

	// One encoded input item: up to four bytes, byte 0 goes out first.
	typedef struct packed {
		logic            emit;      // item produces at least one byte
		logic [1:0]      last_idx;  // index of final byte (count - 1)
		logic            str_last;  // item closes the string
		logic [3:0][7:0] bytes;
	} enc_item_t;

	function automatic enc_item_t encode_unit(
		input logic [15:0] cu,
		input logic        last,
		input logic        pend_v,
		input logic [9:0]  pend_bits
	);
		enc_item_t  r;
		logic       is_hi;
		logic       is_lo;
		logic [20:0] cp;
		is_hi = (cu >= HI_SURR_FIRST) && (cu <= HI_SURR_LAST);
		is_lo = (cu >= LO_SURR_FIRST) && (cu <= LO_SURR_LAST);
		cp    = {1'b0, pend_bits, cu[9:0]} + SUPP_BASE;
		r     = '0;
		r.str_last = last;
		if (pend_v && is_lo) begin
			r.emit     = 1'b1;
			r.last_idx = 2'd3;
			r.bytes[0] = LEAD4 | {5'd0, cp[20:18]};
			r.bytes[1] = CONT | {2'd0, cp[17:12]};
			r.bytes[2] = CONT | {2'd0, cp[11:6]};
			r.bytes[3] = CONT | {2'd0, cp[5:0]};
		end else if (is_hi && !last) begin
			r.emit = 1'b0;
		end else if (cu <= ONE_BYTE_MAX) begin
			r.emit     = 1'b1;
			r.last_idx = 2'd0;
			r.bytes[0] = cu[7:0];
		end else if (cu <= TWO_BYTE_MAX) begin
			r.emit     = 1'b1;
			r.last_idx = 2'd1;
			r.bytes[0] = LEAD2 | {3'd0, cu[10:6]};
			r.bytes[1] = CONT | {2'd0, cu[5:0]};
		end else begin
			r.emit     = 1'b1;
			r.last_idx = 2'd2;
			r.bytes[0] = LEAD3 | {4'd0, cu[15:12]};
			r.bytes[1] = CONT | {2'd0, cu[11:6]};
			r.bytes[2] = CONT | {2'd0, cu[5:0]};
		end
		return r;
	endfunction

endpackage

// File: rtl/core/u16u8_ser.sv
// Byte serializer: holds one encoded item and sends its bytes one per request.
// Depends on u16u8_pkg.
module u16u8_ser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	input  u16u8_pkg::enc_item_t  item,
	output logic                  item_ready,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [7:0]            m_axis_tdata,   // [7:0] out_byte
	output logic                  m_axis_tlast,   // run_last
	output logic                  m_axis_tuser    // [0] string_last
);
	import u16u8_pkg::*;

	enc_item_t  item_s2;
	logic       valid_s2;
	logic [1:0] idx_q;
	logic       at_last;

	assign at_last    = (idx_q == item_s2.last_idx);
	assign item_ready = !valid_s2 || (m_axis_tready && at_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= '0;
		end else if (item_ready) begin
			valid_s2 <= item_valid;
			idx_q    <= '0;
		end else if (m_axis_tready) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s2 <= item;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = item_s2.bytes[idx_q];
	assign m_axis_tlast  = at_last;
	assign m_axis_tuser  = at_last && item_s2.str_last;

endmodule

// File: rtl/core/utf16_to_utf8_converter.sv
// UTF-16 to UTF-8 converter. With the serializer idle, a request is registered into stage 1
// (item_s1) and then into the serializer (item_s2) before its first byte is valid.
// One output byte per cycle while m_axis_tready is high. A unit gives 1 to 4 bytes and
// holds the serializer until its last byte is taken; a held high surrogate gives none.
// Reset (arst_n low, asynchronous) clears the held surrogate and both stage valids.
// Depends on u16u8_pkg and u16u8_ser.
module utf16_to_utf8_converter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] utf16_word
	input  logic        s_axis_tlast,   // last_unit
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
	output logic        m_axis_tlast,   // run_last
	output logic        m_axis_tuser    // [0] string_last
);
	import u16u8_pkg::*;

	logic       pend_valid_q;
	logic [9:0] pend_bits_q;
	enc_item_t  enc;
	enc_item_t  item_s1;
	logic       valid_s1;
	logic       ser_ready;
	logic       in_req;
	logic       is_hi;

	assign enc   = encode_unit(s_axis_tdata, s_axis_tlast, pend_valid_q, pend_bits_q);
	assign is_hi = (s_axis_tdata >= HI_SURR_FIRST) && (s_axis_tdata <= HI_SURR_LAST);

	assign s_axis_tready = !valid_s1 || ser_ready;
	assign in_req        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			pend_bits_q  <= '0;
			valid_s1     <= 1'b0;
		end else begin
			if (in_req) begin
				// a high surrogate not closing the string waits for its partner
				pend_valid_q <= !enc.emit && is_hi;
				pend_bits_q  <= s_axis_tdata[9:0];
				valid_s1     <= enc.emit;
			end else if (ser_ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_req && enc.emit) begin
			item_s1 <= enc;
		end
	end

	u16u8_ser u_ser (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (valid_s1),
		.item          (item_s1),
		.item_ready    (ser_ready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

`ifndef SYNTH
	a_final_clears_pending: assert property (@(posedge clk) disable iff (!arst_n)
		in_req && s_axis_tlast |=> !pend_valid_q)
		else $error("surrogate still held after final unit");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !ser_ready |=> valid_s1 && $stable(item_s1))
		else $error("stage 1 item lost while serializer busy");

	a_str_last_on_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
		else $error("string end flagged on non-final byte of a run");

	a_pending_no_output: assert property (@(posedge clk) disable iff (!arst_n)
		in_req && !enc.emit |=> pend_valid_q)
		else $error("silent item did not leave a held surrogate");
`endif

endmodule
